FILE: src/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that holds at every clock edge out of reset
`define VPA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// a condition that implies another at the same edge
`define VPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/vpa_pkg.sv
// types and constants of the variable partition allocator
package vpa_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int ADDR_BITS    = 16;
    localparam int JOB_BITS     = 8;
    localparam int SIZE_W       = 17;
    localparam int LEN_W        = ADDR_BITS + 1;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 17;
    localparam int STATUS_W     = 3;
    localparam logic [LEN_W-1:0] MEM_CAP = LEN_W'(1) << ADDR_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_POLICY  = 2'd0,
        CFG_MAX_REQUEST = 2'd1,
        CFG_MEMORY_SIZE = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } fit_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_TOO_LARGE   = 3'd1,
        ST_NO_HOLE     = 3'd2,
        ST_TABLE_FULL  = 3'd3,
        ST_UNKNOWN_JOB = 3'd4,
        ST_NOT_ALLOC   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_SCAN,
        SQ_PICK,
        SQ_FREE
    } seq_state_t;

    typedef enum logic [2:0] {
        TBL_NONE,
        TBL_INIT,
        TBL_WRITE,
        TBL_SPLIT,
        TBL_MERGE
    } tbl_op_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LEN_W-1:0]     len;
        logic                 used;
        logic [JOB_BITS-1:0]  owner;
        logic                 marked;
    } entry_t;

    typedef struct packed {
        tbl_op_t          op;
        logic [IDX_W-1:0] idx;
        entry_t           ent;
        entry_t           ent2;
        logic             rm2;
        logic             keep_meta;
    } tbl_cmd_t;

endpackage

FILE: src/vpa_req_if.sv
// request channel of the allocator
interface vpa_req_if;
    import vpa_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [JOB_BITS-1:0] job_id;
    logic [SIZE_W-1:0]   req_size;

    modport source (output valid, output req_type, output job_id, output req_size,
                    input ready);
    modport sink (input valid, input req_type, input job_id, input req_size,
                  output ready);
endinterface

FILE: src/vpa_rsp_if.sv
// response channel of the allocator
interface vpa_rsp_if;
    import vpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_BITS-1:0] seg_start;

    modport source (output valid, output status, output seg_start, input ready);
    modport sink (input valid, input status, input seg_start, output ready);
endinterface

FILE: src/vpa_table.sv
// segment table storage with split and merge shifting
`include "assert_macros.svh"

module vpa_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vpa_pkg::tbl_cmd_t                cmd,
    input  logic [vpa_pkg::IDX_W-1:0]        rd_idx,
    output vpa_pkg::entry_t                  rd_entry,
    output logic [vpa_pkg::CNT_W-1:0]        count
);
    import vpa_pkg::*;

    entry_t            ent_reg  [MAX_SEGMENTS];
    entry_t            ent_next [MAX_SEGMENTS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W:0]    idx_ext;

    assign idx_ext = {1'b0, cmd.idx};

    always_comb
    begin
        ent_next   = ent_reg;
        count_next = count_reg;
        case (cmd.op)
            TBL_INIT:
            begin
                for (int j = 0; j < MAX_SEGMENTS; j++)
                begin
                    ent_next[j].used   = 1'b0;
                    ent_next[j].marked = 1'b0;
                end
                ent_next[0].start = '0;
                ent_next[0].len   = cmd.ent.len;
                count_next        = CNT_W'(1);
            end
            TBL_WRITE:
            begin
                ent_next[cmd.idx] = cmd.ent;
            end
            TBL_SPLIT:
            begin
                for (int j = 0; j < MAX_SEGMENTS; j++)
                begin
                    if ((IDX_W+1)'(j) == idx_ext)
                        ent_next[j] = cmd.ent;
                    else if ((IDX_W+1)'(j) == idx_ext + (IDX_W+1)'(1))
                        ent_next[j] = cmd.ent2;
                    else if (j > 0 && (IDX_W+1)'(j) > idx_ext)
                        ent_next[j] = ent_reg[(j > 0) ? j - 1 : 0];
                end
                count_next = count_reg + CNT_W'(1);
            end
            TBL_MERGE:
            begin
                for (int j = 0; j < MAX_SEGMENTS; j++)
                begin
                    if ((IDX_W+1)'(j) == idx_ext)
                    begin
                        ent_next[j].len  = cmd.ent.len;
                        ent_next[j].used = 1'b0;
                        if (!cmd.keep_meta)
                        begin
                            ent_next[j].owner  = cmd.ent.owner;
                            ent_next[j].marked = cmd.ent.marked;
                        end
                    end
                    else if ((IDX_W+1)'(j) > idx_ext)
                    begin
                        // close the gap left by the removed entries
                        if (cmd.rm2 && j + 2 < MAX_SEGMENTS)
                            ent_next[j] = ent_reg[(j + 2 < MAX_SEGMENTS) ? j + 2 : j];
                        else if (!cmd.rm2 && j + 1 < MAX_SEGMENTS)
                            ent_next[j] = ent_reg[(j + 1 < MAX_SEGMENTS) ? j + 1 : j];
                    end
                end
                count_next = count_reg - (cmd.rm2 ? CNT_W'(2) : CNT_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 1; j < MAX_SEGMENTS; j++)
            begin
                ent_reg[j] <= '0;
            end
            ent_reg[0] <= '{start: '0, len: MEM_CAP, used: 1'b0, owner: '0, marked: 1'b0};
            count_reg  <= CNT_W'(1);
        end
        else
        begin
            ent_reg   <= ent_next;
            count_reg <= count_next;
        end
    end

    assign rd_entry = ent_reg[rd_idx];
    assign count    = count_reg;

    `VPA_ASSERT(a_count_range, count_reg != '0 && count_reg <= CNT_W'(MAX_SEGMENTS),
        "segment count out of range")
    `VPA_ASSERT_IMP(a_split_room, cmd.op == TBL_SPLIT, count_reg < CNT_W'(MAX_SEGMENTS),
        "split with a full table")
    `VPA_ASSERT_IMP(a_merge_room, cmd.op == TBL_MERGE && cmd.rm2, count_reg > CNT_W'(2),
        "double merge with too few entries")

endmodule

FILE: src/vpa_seq.sv
// request sequencer: table scan, placement and release
`include "assert_macros.svh"

module vpa_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    vpa_req_if.sink                            req,
    vpa_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vpa_pkg::CFG_DATA_W-1:0]     cfg_data,
    output vpa_pkg::tbl_cmd_t                  cmd,
    output logic [vpa_pkg::IDX_W-1:0]          rd_idx,
    input  vpa_pkg::entry_t                    rd_entry,
    input  logic [vpa_pkg::CNT_W-1:0]          count
);
    import vpa_pkg::*;

    seq_state_t            state_reg, state_next;
    logic [1:0]            policy_reg, policy_next;
    logic [SIZE_W-1:0]     maxreq_reg, maxreq_next;
    logic [ADDR_BITS-1:0]  rover_reg, rover_next;
    logic                  type_reg, type_next;
    logic [JOB_BITS-1:0]   job_reg, job_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [LEN_W-1:0]      best_len_reg, best_len_next;
    logic                  wrap_found_reg, wrap_found_next;
    logic [IDX_W-1:0]      wrap_reg, wrap_next;
    logic                  prev_used_reg, prev_used_next;
    logic [LEN_W-1:0]      prev_len_reg, prev_len_next;
    logic                  prev_free_reg, prev_free_next;
    logic [LEN_W-1:0]      pl_reg, pl_next;
    logic [ADDR_BITS-1:0]  k_start_reg, k_start_next;
    logic                  just_reg, just_next;
    logic                  next_free_reg, next_free_next;
    logic [LEN_W-1:0]      next_len_reg, next_len_next;
    logic [JOB_BITS-1:0]   next_owner_reg, next_owner_next;
    logic                  next_tag_reg, next_tag_next;
    logic                  tag_hit_reg, tag_hit_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [ADDR_BITS-1:0]  out_start_reg, out_start_next;

    logic                  accept;
    logic                  fits;
    logic                  last;
    logic                  any_hole;
    logic [IDX_W-1:0]      hsel;
    logic [LEN_W-1:0]      size_len;
    logic [LEN_W-1:0]      mem_len;
    logic [LEN_W:0]        cfg_ext;

    assign req.ready     = (state_reg == SQ_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept        = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.seg_start = out_start_reg;

    assign size_len = LEN_W'(size_reg);
    assign fits     = !rd_entry.used && rd_entry.len >= size_len;
    assign last     = ({1'b0, idx_reg} + (IDX_W+1)'(1)) == (IDX_W+1)'(count);
    assign any_hole = (policy_reg == FIT_NEXT) ? wrap_found_reg : found_reg;
    assign hsel     = (policy_reg == FIT_NEXT && !found_reg) ? wrap_reg : best_reg;

    // memory size clamped to one .. 2^ADDR_BITS
    assign cfg_ext = (LEN_W+1)'(cfg_data);
    always_comb
    begin
        if (cfg_ext == '0)
            mem_len = LEN_W'(1);
        else if (cfg_ext > (LEN_W+1)'(MEM_CAP))
            mem_len = MEM_CAP;
        else
            mem_len = cfg_ext[LEN_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        policy_next     = policy_reg;
        maxreq_next     = maxreq_reg;
        rover_next      = rover_reg;
        type_next       = type_reg;
        job_next        = job_reg;
        size_next       = size_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_len_next   = best_len_reg;
        wrap_found_next = wrap_found_reg;
        wrap_next       = wrap_reg;
        prev_used_next  = prev_used_reg;
        prev_len_next   = prev_len_reg;
        prev_free_next  = prev_free_reg;
        pl_next         = pl_reg;
        k_start_next    = k_start_reg;
        just_next       = 1'b0;
        next_free_next  = next_free_reg;
        next_len_next   = next_len_reg;
        next_owner_next = next_owner_reg;
        next_tag_next   = next_tag_reg;
        tag_hit_next    = tag_hit_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        cmd             = '0;
        cmd.op          = TBL_NONE;
        rd_idx          = idx_reg;

        case (state_reg)
            SQ_IDLE:
            begin
                if (cfg_we)
                begin
                    case (cfg_index)
                        CFG_FIT_POLICY:  policy_next = cfg_data[1:0];
                        CFG_MAX_REQUEST: maxreq_next = SIZE_W'(cfg_data);
                        CFG_MEMORY_SIZE:
                        begin
                            cmd.op      = TBL_INIT;
                            cmd.ent.len = mem_len;
                            rover_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (accept)
                begin
                    type_next       = req.req_type;
                    job_next        = req.job_id;
                    size_next       = req.req_size;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    wrap_found_next = 1'b0;
                    prev_used_next  = 1'b1;
                    prev_free_next  = 1'b0;
                    next_free_next  = 1'b0;
                    tag_hit_next    = 1'b0;
                    if (req.req_type == REQ_ALLOC && req.req_size > maxreq_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_TOO_LARGE;
                        out_start_next  = '0;
                    end
                    else if (req.req_type == REQ_ALLOC && req.req_size == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_NO_HOLE;
                        out_start_next  = '0;
                    end
                    else
                    begin
                        state_next = SQ_SCAN;
                    end
                end
            end
            SQ_SCAN:
            begin
                if (type_reg == REQ_ALLOC)
                begin
                    case (policy_reg)
                        FIT_NEXT:
                        begin
                            if (fits && !wrap_found_reg)
                            begin
                                wrap_found_next = 1'b1;
                                wrap_next       = idx_reg;
                            end
                            if (fits && !found_reg && rd_entry.start >= rover_reg)
                            begin
                                found_next = 1'b1;
                                best_next  = idx_reg;
                            end
                        end
                        FIT_BEST:
                        begin
                            if (fits && (!found_reg || rd_entry.len < best_len_reg))
                            begin
                                found_next    = 1'b1;
                                best_next     = idx_reg;
                                best_len_next = rd_entry.len;
                            end
                        end
                        FIT_WORST:
                        begin
                            if (fits && (!found_reg || rd_entry.len > best_len_reg))
                            begin
                                found_next    = 1'b1;
                                best_next     = idx_reg;
                                best_len_next = rd_entry.len;
                            end
                        end
                        default:
                        begin
                            if (fits && !found_reg)
                            begin
                                found_next = 1'b1;
                                best_next  = idx_reg;
                            end
                        end
                    endcase
                end
                else
                begin
                    if (!found_reg && rd_entry.used && rd_entry.owner == job_reg)
                    begin
                        found_next     = 1'b1;
                        just_next      = 1'b1;
                        best_next      = idx_reg;
                        best_len_next  = rd_entry.len;
                        k_start_next   = rd_entry.start;
                        prev_free_next = !prev_used_reg;
                        pl_next        = prev_len_reg;
                    end
                    // entry right after the one being released
                    if (just_reg)
                    begin
                        next_free_next  = !rd_entry.used;
                        next_len_next   = rd_entry.len;
                        next_owner_next = rd_entry.owner;
                        next_tag_next   = rd_entry.marked;
                    end
                    if (!rd_entry.used && rd_entry.marked && rd_entry.owner == job_reg)
                        tag_hit_next = 1'b1;
                    prev_used_next = rd_entry.used;
                    prev_len_next  = rd_entry.len;
                end
                if (last)
                    state_next = (type_reg == REQ_ALLOC) ? SQ_PICK : SQ_FREE;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            SQ_PICK:
            begin
                rd_idx          = hsel;
                state_next      = SQ_IDLE;
                out_valid_next  = 1'b1;
                out_start_next  = '0;
                if (!any_hole)
                begin
                    out_status_next = ST_NO_HOLE;
                end
                else if (rd_entry.len != size_len && count >= CNT_W'(MAX_SEGMENTS))
                begin
                    out_status_next = ST_TABLE_FULL;
                end
                else
                begin
                    cmd.idx         = hsel;
                    cmd.ent.start   = rd_entry.start;
                    cmd.ent.len     = size_len;
                    cmd.ent.used    = 1'b1;
                    cmd.ent.owner   = job_reg;
                    cmd.ent.marked  = 1'b0;
                    cmd.ent2.start  = ADDR_BITS'(rd_entry.start + ADDR_BITS'(size_reg));
                    cmd.ent2.len    = rd_entry.len - size_len;
                    cmd.ent2.used   = 1'b0;
                    cmd.ent2.owner  = rd_entry.owner;
                    cmd.ent2.marked = rd_entry.marked;
                    cmd.op          = (rd_entry.len == size_len) ? TBL_WRITE : TBL_SPLIT;
                    rover_next      = ADDR_BITS'(rd_entry.start + ADDR_BITS'(size_reg));
                    out_status_next = ST_OK;
                    out_start_next  = rd_entry.start;
                end
            end
            SQ_FREE:
            begin
                state_next     = SQ_IDLE;
                out_valid_next = 1'b1;
                out_start_next = '0;
                if (!found_reg)
                begin
                    out_status_next = tag_hit_reg ? ST_NOT_ALLOC : ST_UNKNOWN_JOB;
                end
                else
                begin
                    out_status_next = ST_OK;
                    out_start_next  = k_start_reg;
                    if (prev_free_reg)
                    begin
                        cmd.op        = TBL_MERGE;
                        cmd.idx       = best_reg - IDX_W'(1);
                        cmd.ent.len   = pl_reg + best_len_reg
                                        + (next_free_reg ? next_len_reg : '0);
                        cmd.rm2       = next_free_reg;
                        cmd.keep_meta = 1'b1;
                    end
                    else if (next_free_reg)
                    begin
                        cmd.op         = TBL_MERGE;
                        cmd.idx        = best_reg;
                        cmd.ent.len    = best_len_reg + next_len_reg;
                        cmd.ent.owner  = next_owner_reg;
                        cmd.ent.marked = next_tag_reg;
                    end
                    else
                    begin
                        cmd.op         = TBL_WRITE;
                        cmd.idx        = best_reg;
                        cmd.ent.start  = k_start_reg;
                        cmd.ent.len    = best_len_reg;
                        cmd.ent.used   = 1'b0;
                        cmd.ent.owner  = job_reg;
                        cmd.ent.marked = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            policy_reg    <= FIT_FIRST;
            maxreq_reg    <= SIZE_W'(MEM_CAP);
            rover_reg     <= '0;
            out_valid_reg <= 1'b0;
            just_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            maxreq_reg    <= maxreq_next;
            rover_reg     <= rover_next;
            out_valid_reg <= out_valid_next;
            just_reg      <= just_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg       <= type_next;
        job_reg        <= job_next;
        size_reg       <= size_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        best_reg       <= best_next;
        best_len_reg   <= best_len_next;
        wrap_found_reg <= wrap_found_next;
        wrap_reg       <= wrap_next;
        prev_used_reg  <= prev_used_next;
        prev_len_reg   <= prev_len_next;
        prev_free_reg  <= prev_free_next;
        pl_reg         <= pl_next;
        k_start_reg    <= k_start_next;
        next_free_reg  <= next_free_next;
        next_len_reg   <= next_len_next;
        next_owner_reg <= next_owner_next;
        next_tag_reg   <= next_tag_next;
        tag_hit_reg    <= tag_hit_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
    end

    `VPA_ASSERT_IMP(a_ready_idle, req.ready, state_reg == SQ_IDLE && (!out_valid_reg || rsp.ready),
        "ready outside idle or with a blocked result")
    `VPA_ASSERT_IMP(a_table_busy_only, cmd.op == TBL_SPLIT || cmd.op == TBL_MERGE,
        state_reg == SQ_PICK || state_reg == SQ_FREE, "table reshaped outside placement")
    `VPA_ASSERT_IMP(a_err_start_zero, rsp.valid && rsp.status != ST_OK, rsp.seg_start == '0,
        "error result with nonzero start")

endmodule

FILE: src/variable_partition_allocator.sv
// top level of the variable partition allocator
// A request (allocate or free) is taken when the block is idle and the result register is
// free or being emptied. The sequencer then walks the segment table one entry per cycle and
// answers after the walk; allocations rejected as too large or of size zero skip the walk
// and answer in the cycle after acceptance. Splits and merges reshape the table in one
// command after the walk. A write of memory_size resets the table to one free segment and
// the next-fit rover to zero.
module variable_partition_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    vpa_req_if.sink                            req,
    vpa_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vpa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vpa_pkg::*;

    tbl_cmd_t          cmd;
    logic [IDX_W-1:0]  rd_idx;
    entry_t            rd_entry;
    logic [CNT_W-1:0]  count;

    vpa_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rd_idx    (rd_idx),
        .rd_entry  (rd_entry),
        .count     (count)
    );

    vpa_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .count    (count)
    );

endmodule

FILE: dv/vpa_checker.sv
// transaction checker and segment-table predictor of the partition allocator
`timescale 1ns / 100ps

module vpa_checker
    import vpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    vpa_req_if                    req,
    vpa_rsp_if                    rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef struct {
        status_t              status;
        logic [ADDR_BITS-1:0] start;
    } outcome_t;

    logic [ADDR_BITS-1:0] seg_start_q [MAX_SEGMENTS];
    logic [LEN_W-1:0]     seg_len     [MAX_SEGMENTS];
    logic                 seg_used    [MAX_SEGMENTS];
    logic [JOB_BITS-1:0]  seg_owner   [MAX_SEGMENTS];
    logic                 seg_tag     [MAX_SEGMENTS];
    int                   seg_count;
    logic [ADDR_BITS-1:0] rover;
    fit_t                 fit;
    logic [SIZE_W-1:0]    max_req;
    logic [LEN_W-1:0]     mem_len;
    outcome_t             awaited [$];

    task automatic clear_table();
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            seg_start_q[i] = '0;
            seg_len[i]     = '0;
            seg_used[i]    = 1'b0;
            seg_owner[i]   = '0;
            seg_tag[i]     = 1'b0;
        end
        seg_len[0] = mem_len;
        seg_count  = 1;
        rover      = '0;
    endtask

    task automatic move_entry(int to, int from);
        seg_start_q[to] = seg_start_q[from];
        seg_len[to]     = seg_len[from];
        seg_used[to]    = seg_used[from];
        seg_owner[to]   = seg_owner[from];
        seg_tag[to]     = seg_tag[from];
    endtask

    task automatic drop_entry(int k);
        for (int j = k; j + 1 < seg_count; j++)
            move_entry(j, j + 1);
        seg_count--;
    endtask

    function automatic int choose_hole(logic [LEN_W-1:0] size);
        int pick;
        int wrap;
        pick = MAX_SEGMENTS;
        wrap = MAX_SEGMENTS;
        for (int i = 0; i < seg_count; i++)
        begin
            if (seg_used[i] || seg_len[i] < size)
                continue;
            case (fit)
                FIT_NEXT:
                begin
                    if (wrap == MAX_SEGMENTS)
                        wrap = i;
                    if (pick == MAX_SEGMENTS && seg_start_q[i] >= rover)
                        pick = i;
                end
                FIT_BEST:
                    if (pick == MAX_SEGMENTS || seg_len[i] < seg_len[pick])
                        pick = i;
                FIT_WORST:
                    if (pick == MAX_SEGMENTS || seg_len[i] > seg_len[pick])
                        pick = i;
                default:
                    if (pick == MAX_SEGMENTS)
                        pick = i;
            endcase
        end
        if (fit == FIT_NEXT && pick == MAX_SEGMENTS)
            pick = wrap;
        return pick;
    endfunction

    task automatic allocate(logic [JOB_BITS-1:0] job, logic [SIZE_W-1:0] size,
                            output outcome_t res);
        int h;
        logic [ADDR_BITS-1:0] s;
        res.status = ST_OK;
        res.start  = '0;
        if (size > max_req)
            res.status = ST_TOO_LARGE;
        else if (size == 0)
            res.status = ST_NO_HOLE;
        else
        begin
            h = choose_hole(size);
            if (h >= MAX_SEGMENTS)
                res.status = ST_NO_HOLE;
            else if (seg_len[h] != size && seg_count >= MAX_SEGMENTS)
                res.status = ST_TABLE_FULL;
            else
            begin
                s = seg_start_q[h];
                if (seg_len[h] != size)
                begin
                    // open a slot after the hole for the leftover part
                    for (int j = seg_count; j > h; j--)
                        move_entry(j, j - 1);
                    seg_count++;
                    seg_start_q[h + 1] = ADDR_BITS'(s + size);
                    seg_len[h + 1]     = seg_len[h + 1] - size;
                    seg_len[h]         = size;
                end
                seg_used[h]  = 1'b1;
                seg_owner[h] = job;
                seg_tag[h]   = 1'b0;
                rover        = ADDR_BITS'(s + size);
                res.start    = s;
            end
        end
    endtask

    task automatic free_entry(logic [JOB_BITS-1:0] job, output outcome_t res);
        int k;
        logic prev_free;
        logic next_free;
        k = MAX_SEGMENTS;
        res.status = ST_OK;
        res.start  = '0;
        for (int i = 0; i < seg_count; i++)
            if (k == MAX_SEGMENTS && seg_used[i] && seg_owner[i] == job)
                k = i;
        if (k == MAX_SEGMENTS)
        begin
            res.status = ST_UNKNOWN_JOB;
            for (int i = 0; i < seg_count; i++)
                if (!seg_used[i] && seg_tag[i] && seg_owner[i] == job)
                    res.status = ST_NOT_ALLOC;
        end
        else
        begin
            res.start = seg_start_q[k];
            prev_free = k > 0 && !seg_used[k - 1];
            next_free = k + 1 < seg_count && !seg_used[k + 1];
            seg_used[k] = 1'b0;
            if (prev_free)
            begin
                seg_len[k - 1] = seg_len[k - 1] + seg_len[k];
                if (next_free)
                begin
                    seg_len[k - 1] = seg_len[k - 1] + seg_len[k + 1];
                    drop_entry(k + 1);
                end
                drop_entry(k);
            end
            else if (next_free)
            begin
                // the merged hole keeps the successor's tag
                seg_len[k]   = seg_len[k] + seg_len[k + 1];
                seg_owner[k] = seg_owner[k + 1];
                seg_tag[k]   = seg_tag[k + 1];
                drop_entry(k + 1);
            end
            else
                seg_tag[k] = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            fit     = FIT_FIRST;
            max_req = SIZE_W'(65536);
            mem_len = MEM_CAP;
            clear_table();
            awaited.delete();
            errors  = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected response status %0d start %0d",
                                 $realtime, rsp.status, rsp.seg_start);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (rsp.status !== want.status || rsp.seg_start !== want.start)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch status %0d/%0d start %0d/%0d (exp/got)",
                                     $realtime, want.status, rsp.status, want.start,
                                     rsp.seg_start);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_FREE)
                    free_entry(req.job_id, got);
                else
                    allocate(req.job_id, req.req_size, got);
                awaited.push_back(got);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIT_POLICY:  fit = fit_t'(cfg_data[1:0]);
                    CFG_MAX_REQUEST: max_req = cfg_data;
                    CFG_MEMORY_SIZE:
                    begin
                        if (cfg_data == 0)
                            mem_len = LEN_W'(1);
                        else if (cfg_data > MEM_CAP)
                            mem_len = MEM_CAP;
                        else
                            mem_len = cfg_data;
                        clear_table();
                    end
                    default: ;
                endcase
            end
        end
        pending = awaited.size();
    end

endmodule

FILE: dv/tb_top.sv
// top of the partition allocator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;
    import vpa_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    hold_cycles;
    bit                    quiet;
    int                    mem_cur;

    vpa_req_if req ();
    vpa_rsp_if rsp ();

    variable_partition_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vpa_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // response side: random stall bursts, one long hold-off, none when quiet
    initial
    begin
        int burst;
        burst = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp.ready = 1'b0;
            end
            else if (quiet)
                rsp.ready = 1'b1;
            else if (burst > 0)
            begin
                burst--;
                rsp.ready = 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 15);
                rsp.ready = 1'b0;
            end
            else
                rsp.ready = 1'b1;
        end
    end

    task automatic send(req_type_t kind, logic [JOB_BITS-1:0] job, logic [SIZE_W-1:0] size);
        bit taken;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        req.valid    = 1'b1;
        req.req_type = kind;
        req.job_id   = job;
        req.req_size = size;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = req.ready;
        end
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        while (pending != 0)
            @(posedge clk);
        repeat (MAX_SEGMENTS + 4) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        if (idx == CFG_MEMORY_SIZE)
            mem_cur = (value == 0) ? 1 : (value > MEM_CAP) ? int'(MEM_CAP) : int'(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_random();
        logic [JOB_BITS-1:0] job;
        logic [SIZE_W-1:0]   size;
        int                  pick;
        job  = ($urandom_range(0, 7) == 0) ? JOB_BITS'($urandom)
                                            : JOB_BITS'($urandom_range(0, 7));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            size = SIZE_W'($urandom);
        else if (pick == 1)
            size = '0;
        else
            size = SIZE_W'($urandom_range(1, (mem_cur > 3) ? mem_cur / 3 : 1));
        if ($urandom_range(0, 9) < 4)
            send(REQ_FREE, job, SIZE_W'($urandom));
        else
            send(REQ_ALLOC, job, size);
    endtask

    initial
    begin
        int mem_sel;
        int wait_cnt;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_FIT_POLICY;
        cfg_data     = '0;
        req.valid    = 1'b0;
        req.req_type = REQ_ALLOC;
        req.job_id   = '0;
        req.req_size = '0;
        hold_cycles  = 0;
        quiet        = 1'b0;
        mem_cur      = 65536;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: whole memory, first fit
        send(REQ_ALLOC, 8'd0, 17'd0);
        send(REQ_ALLOC, 8'd255, 17'd65536);
        send(REQ_ALLOC, 8'd1, 17'd1);
        send(REQ_FREE, 8'd255, 17'h1FFFF);
        send(REQ_FREE, 8'd255, 17'd0);
        send(REQ_FREE, 8'd7, 17'd0);
        send(REQ_ALLOC, 8'd1, 17'h1FFFF);

        // fill the table with unit pieces until a split is refused
        write_reg(CFG_MEMORY_SIZE, 17'd64);
        for (int j = 0; j < 16; j++)
            send(REQ_ALLOC, JOB_BITS'(10 + j), 17'd1);
        send(REQ_ALLOC, 8'd40, 17'd49);
        send(REQ_FREE, 8'd11, 17'd0);
        send(REQ_FREE, 8'd12, 17'd0);
        send(REQ_FREE, 8'd14, 17'd0);
        send(REQ_FREE, 8'd13, 17'd0);

        for (int phase = 0; phase < 9; phase++)
        begin
            write_reg(CFG_FIT_POLICY, CFG_DATA_W'({$urandom, 2'(phase)}));
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_MAX_REQUEST, 17'd0);
                1:       write_reg(CFG_MAX_REQUEST, 17'd65536);
                2:       write_reg(CFG_MAX_REQUEST, 17'h1FFFF);
                default: write_reg(CFG_MAX_REQUEST, CFG_DATA_W'($urandom_range(1, 40)));
            endcase
            mem_sel = $urandom_range(0, 9);
            if (phase == 0 || mem_sel == 0)
                write_reg(CFG_MEMORY_SIZE, 17'd65536);
            else if (mem_sel == 1)
                write_reg(CFG_MEMORY_SIZE, 17'd0);
            else if (mem_sel == 2)
                write_reg(CFG_MEMORY_SIZE, 17'h1FFFF);
            else if (mem_sel == 3)
                write_reg(CFG_MEMORY_SIZE, 17'd1);
            else
                write_reg(CFG_MEMORY_SIZE, CFG_DATA_W'($urandom_range(2, 96)));
            if (phase == 2)
                hold_cycles = 400;
            if (phase == 8)
                quiet = 1'b1;
            for (int n = 0; n < 200; n++)
                send_random();
        end

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (MAX_SEGMENTS + 8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
